// ===== rtl/prd_pkg.sv =====
// Shared types and constants for the digipeater path rewriter.
// Used by prd_ctrl, prd_dp and the top level; depends on nothing.
package prd_pkg;

  localparam int CALL_W  = 48;
  localparam int SSID_W  = 4;
  localparam int ENTRY_W = CALL_W + SSID_W + 1;
  localparam int CFG_W   = 48;
  localparam int CFG_IW  = 3;

  localparam logic KIND_SRC = 1'b0;
  localparam logic KIND_HOP = 1'b1;

  typedef enum logic [2:0] {
    V_REPEAT   = 3'd0,
    V_OWN_PKT  = 3'd1,
    V_ALREADY  = 3'd2,
    V_NO_MATCH = 3'd3,
    V_USED_UP  = 3'd4,
    V_FULL     = 3'd5
  } verdict_t;

  typedef enum logic [1:0] {
    M_NONE = 2'd0,
    M_MARK = 2'd1,
    M_DEC  = 2'd2,
    M_INS  = 2'd3
  } mode_t;

  typedef enum logic [CFG_IW-1:0] {
    R_STN_CALL  = 3'd0,
    R_OWN_SSID  = 3'd1,
    R_A_CALL    = 3'd2,
    R_A_HOPS    = 3'd3,
    R_A_TRACED  = 3'd4,
    R_B_CALL    = 3'd5,
    R_B_HOPS    = 3'd6,
    R_B_TRACED  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [CALL_W-1:0] stn_call;
    logic [SSID_W-1:0] own_ssid;
    logic [CALL_W-1:0] a_call;
    logic [2:0]        a_hops;
    logic              a_traced;
    logic [CALL_W-1:0] b_call;
    logic [2:0]        b_hops;
    logic              b_traced;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic decide;
    logic read;
    logic advance;
    logic clear;
  } dp_cmd_t;

  typedef struct packed {
    logic path_empty;
    logic final_item;
  } dp_sts_t;

endpackage

// ===== rtl/packet_radio_path_digipeater_unit.sv =====
// Top level of the digipeater path rewriter: ports, configuration registers, wiring.
// Depends on prd_pkg, prd_ctrl and prd_dp.
//
//   channel  dir  handshake            payload
//   in_      in   in_tvalid/in_tready  tdata call,ssid,rep; tuser kind; tlast last
//   out_     out  out_tvalid/out_tready tdata verdict,call,ssid,rep; tuser entry_valid
//   cfg_     in   cfg_we               cfg_index, cfg_data
//
// Address items are taken one per cycle while the block is in its input phase.
// After a last item the block forms the verdict, then walks the results, each one
// a path memory read and then a show that waits for out_tready; an empty path
// gives one result, shown without a memory read.
// No input is taken from the last item until the final result is taken.
// Reset is synchronous; it clears the packet state and the configuration registers.
module packet_radio_path_digipeater_unit #(
  parameter int MAX_PATH   = 8,
  parameter int CALL_CHARS = 6
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [55:0]                  in_tdata,   // callsign[47:0], ssid, repeated, zero pad
  input  logic                         in_tuser,   // kind
  input  logic                         in_tlast,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [55:0]                  out_tdata,  // verdict, callsign, ssid, repeated
  output logic                         out_tuser,  // entry_valid
  output logic                         out_tlast,
  input  logic                         cfg_we,
  input  logic [prd_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [prd_pkg::CFG_W-1:0]    cfg_data
);

  prd_pkg::cfg_t    cfg_r;
  prd_pkg::dp_cmd_t cmd;
  prd_pkg::dp_sts_t sts;

  logic [2:0]                 o_verdict;
  logic [prd_pkg::CALL_W-1:0] o_call;
  logic [prd_pkg::SSID_W-1:0] o_ssid;
  logic                       o_rep;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (prd_pkg::reg_idx_t'(cfg_index))
        prd_pkg::R_STN_CALL: cfg_r.stn_call <= cfg_data;
        prd_pkg::R_OWN_SSID: cfg_r.own_ssid <= cfg_data[prd_pkg::SSID_W-1:0];
        prd_pkg::R_A_CALL:   cfg_r.a_call   <= cfg_data;
        prd_pkg::R_A_HOPS:   cfg_r.a_hops   <= cfg_data[2:0];
        prd_pkg::R_A_TRACED: cfg_r.a_traced <= cfg_data[0];
        prd_pkg::R_B_CALL:   cfg_r.b_call   <= cfg_data;
        prd_pkg::R_B_HOPS:   cfg_r.b_hops   <= cfg_data[2:0];
        prd_pkg::R_B_TRACED: cfg_r.b_traced <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  prd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  prd_dp #(
    .MAX_PATH   (MAX_PATH),
    .CALL_CHARS (CALL_CHARS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .cfg           (cfg_r),
    .in_kind       (in_tuser),
    .in_call       (in_tdata[47:0]),
    .in_ssid       (in_tdata[51:48]),
    .in_rep        (in_tdata[52]),
    .o_verdict     (o_verdict),
    .o_entry_valid (out_tuser),
    .o_call        (o_call),
    .o_ssid        (o_ssid),
    .o_rep         (o_rep),
    .o_last        (out_tlast)
  );

  assign out_tdata = {o_rep, o_ssid, o_call, o_verdict};

endmodule

// ===== rtl/prd_ctrl.sv =====
// Controller for the digipeater path rewriter: input phase, verdict, result walk.
// Depends on prd_pkg; drives prd_dp through command and status structs.
module prd_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_tlast,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  output prd_pkg::dp_cmd_t cmd,
  input  prd_pkg::dp_sts_t sts
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_DECIDE = 4'b0010,
    S_READ   = 4'b0100,
    S_SHOW   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    in_tready   = 1'b0;
    out_tvalid  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
        if (in_tvalid && in_tlast) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = sts.path_empty ? S_SHOW : S_READ;
      end
      S_READ: begin
        cmd.read  = 1'b1;
        state_nxt = S_SHOW;
      end
      S_SHOW: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          if (sts.final_item) begin
            cmd.clear = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            cmd.advance = 1'b1;
            state_nxt   = S_READ;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input and output phases overlap");

  a_final_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && sts.final_item |=> in_tready)
    else $error("final result not followed by input phase");

  a_decide_next: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.decide |=> (state_r == S_READ || state_r == S_SHOW))
    else $error("verdict not followed by result walk");

endmodule

// ===== rtl/prd_dp.sv =====
// Datapath for the digipeater path rewriter: path memory, matching, verdict, rewrite.
// Depends on prd_pkg; commanded by prd_ctrl.
module prd_dp #(
  parameter int MAX_PATH   = 8,
  parameter int CALL_CHARS = 6
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  prd_pkg::dp_cmd_t            cmd,
  output prd_pkg::dp_sts_t            sts,
  input  prd_pkg::cfg_t               cfg,
  input  logic                        in_kind,
  input  logic [prd_pkg::CALL_W-1:0]  in_call,
  input  logic [prd_pkg::SSID_W-1:0]  in_ssid,
  input  logic                        in_rep,
  output logic [2:0]                  o_verdict,
  output logic                        o_entry_valid,
  output logic [prd_pkg::CALL_W-1:0]  o_call,
  output logic [prd_pkg::SSID_W-1:0]  o_ssid,
  output logic                        o_rep,
  output logic                        o_last
);

  localparam int CW    = $clog2(MAX_PATH + 1);
  localparam int IW    = $clog2(MAX_PATH);
  localparam int BYTES = (CALL_CHARS < 6) ? CALL_CHARS : 6;
  localparam logic [CW-1:0] MAX_C = CW'(MAX_PATH);
  localparam logic [CW-1:0] ONE_C = CW'(1);

  function automatic logic [prd_pkg::CALL_W-1:0] fold(input logic [prd_pkg::CALL_W-1:0] c);
    logic [prd_pkg::CALL_W-1:0] r;
    logic [7:0] b;
    r = '0;
    for (int k = 0; k < 6; k++) begin
      b = c[8*k +: 8];
      if (b >= 8'h61 && b <= 8'h7a) begin
        b = b - 8'h20;
      end
      if (k < BYTES) begin
        r[8*k +: 8] = b;
      end
    end
    return r;
  endfunction

  logic [prd_pkg::ENTRY_W-1:0] mem [MAX_PATH];
  logic [prd_pkg::ENTRY_W-1:0] rd_r;

  logic [CW-1:0] cnt_r, total_r, k_r;
  logic          src_own_r, own_found_r, own_rep_r, alias_found_r, alias_which_r;
  logic [IW-1:0] own_pos_r, alias_pos_r, tgt_r;
  logic [prd_pkg::SSID_W-1:0] alias_ssid_r;
  prd_pkg::verdict_t verdict_r, verdict_nxt;
  prd_pkg::mode_t    mode_r, mode_nxt;
  logic [IW-1:0]     tgt_nxt;
  logic [CW-1:0]     total_nxt;

  logic [prd_pkg::CALL_W-1:0] in_fold;
  logic own_m, hit_a, hit_b, room, traced;
  logic [CW-1:0] rd_addr;

  assign in_fold = fold(in_call);
  assign own_m   = (in_fold == fold(cfg.stn_call)) && (in_ssid == cfg.own_ssid);
  assign hit_a   = (cfg.a_call != '0) && (in_fold == fold(cfg.a_call))
                   && (in_ssid <= {1'b0, cfg.a_hops});
  assign hit_b   = (cfg.b_call != '0) && (in_fold == fold(cfg.b_call))
                   && (in_ssid <= {1'b0, cfg.b_hops});
  assign room    = cnt_r < MAX_C;
  assign traced  = alias_which_r ? cfg.b_traced : cfg.a_traced;

  always_comb begin
    verdict_nxt = prd_pkg::V_REPEAT;
    mode_nxt    = prd_pkg::M_NONE;
    tgt_nxt     = alias_pos_r;
    total_nxt   = cnt_r;
    priority if (src_own_r) begin
      verdict_nxt = prd_pkg::V_OWN_PKT;
    end else if (own_found_r) begin
      tgt_nxt = own_pos_r;
      if (own_rep_r) begin
        verdict_nxt = prd_pkg::V_ALREADY;
      end else begin
        mode_nxt = prd_pkg::M_MARK;
      end
    end else if (!alias_found_r) begin
      verdict_nxt = prd_pkg::V_NO_MATCH;
    end else if (alias_ssid_r == '0) begin
      verdict_nxt = prd_pkg::V_USED_UP;
    end else if (!traced) begin
      mode_nxt = prd_pkg::M_DEC;
    end else if (!room) begin
      verdict_nxt = prd_pkg::V_FULL;
    end else begin
      mode_nxt  = prd_pkg::M_INS;
      total_nxt = cnt_r + ONE_C;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r         <= '0;
      src_own_r     <= 1'b0;
      own_found_r   <= 1'b0;
      alias_found_r <= 1'b0;
      alias_which_r <= 1'b0;
      total_r       <= '0;
      k_r           <= '0;
      mode_r        <= prd_pkg::M_NONE;
      verdict_r     <= prd_pkg::V_REPEAT;
    end else begin
      if (cmd.clear || (cmd.accept && in_kind == prd_pkg::KIND_SRC)) begin
        cnt_r         <= '0;
        src_own_r     <= cmd.accept && own_m;
        own_found_r   <= 1'b0;
        alias_found_r <= 1'b0;
        alias_which_r <= 1'b0;
      end else if (cmd.accept && room) begin
        cnt_r <= cnt_r + ONE_C;
        if (!own_found_r && own_m) begin
          own_found_r <= 1'b1;
          own_pos_r   <= cnt_r[IW-1:0];
          own_rep_r   <= in_rep;
        end
        if (!in_rep && !alias_found_r && (hit_a || hit_b)) begin
          alias_found_r <= 1'b1;
          alias_pos_r   <= cnt_r[IW-1:0];
          alias_which_r <= !hit_a;
          alias_ssid_r  <= in_ssid;
        end
      end
      if (cmd.decide) begin
        verdict_r <= verdict_nxt;
        mode_r    <= mode_nxt;
        tgt_r     <= tgt_nxt;
        total_r   <= total_nxt;
        k_r       <= '0;
      end else if (cmd.advance) begin
        k_r <= k_r + ONE_C;
      end
    end
  end

  assign rd_addr = (mode_r == prd_pkg::M_INS && k_r > CW'(tgt_r)) ? k_r - ONE_C : k_r;

  always_ff @(posedge clk) begin
    if (cmd.accept && in_kind == prd_pkg::KIND_HOP && room) begin
      mem[cnt_r[IW-1:0]] <= {in_call, in_ssid, in_rep};
    end
    if (cmd.read) begin
      rd_r <= mem[rd_addr[IW-1:0]];
    end
  end

  logic [prd_pkg::CALL_W-1:0] e_call;
  logic [prd_pkg::SSID_W-1:0] e_ssid, dec_ssid;
  logic e_rep, at_tgt, at_next;

  assign e_call   = rd_r[prd_pkg::ENTRY_W-1 -: prd_pkg::CALL_W];
  assign e_ssid   = rd_r[prd_pkg::SSID_W:1];
  assign e_rep    = rd_r[0];
  assign dec_ssid = e_ssid - prd_pkg::SSID_W'(1);
  assign at_tgt   = k_r == CW'(tgt_r);
  assign at_next  = k_r == CW'(tgt_r) + ONE_C;

  always_comb begin
    o_verdict     = verdict_r;
    o_entry_valid = 1'b1;
    o_call        = e_call;
    o_ssid        = e_ssid;
    o_rep         = e_rep;
    if (total_r == '0) begin
      o_entry_valid = 1'b0;
      o_call        = '0;
      o_ssid        = '0;
      o_rep         = 1'b0;
    end else begin
      unique case (mode_r)
        prd_pkg::M_MARK: begin
          if (at_tgt) begin
            o_rep = 1'b1;
          end
        end
        prd_pkg::M_DEC: begin
          if (at_tgt) begin
            o_ssid = dec_ssid;
            o_rep  = e_rep | (dec_ssid == '0);
          end
        end
        prd_pkg::M_INS: begin
          if (at_tgt) begin
            o_call = cfg.stn_call;
            o_ssid = cfg.own_ssid;
            o_rep  = 1'b1;
          end else if (at_next) begin
            o_ssid = dec_ssid;
            o_rep  = e_rep | (dec_ssid == '0);
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign sts.final_item = (total_r == '0) || (k_r + ONE_C == total_r);
  assign sts.path_empty = (total_nxt == '0);
  assign o_last         = sts.final_item;

endmodule
